FILE: rtl/assert_macros.svh
// Assertion helpers; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that an antecedent implies a consequent at the same edge.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ped_pkg.sv
package ped_pkg;

    localparam int COORD_W     = 16;
    localparam int POINT_W     = 8;
    localparam int DIM_W       = 2;
    localparam int DIST_W      = 17;
    localparam int CFG_W       = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic                  OP_WRITE         = 1'b0;
    localparam logic                  OP_QUERY         = 1'b1;
    localparam logic [APB_ADDR_W-1:0] ADDR_DIMS_IN_USE = 3'd0;
    localparam logic [CFG_W-1:0]      DIMS_RESET       = 3'd4;

    typedef logic signed [COORD_W-1:0] coord_t;

endpackage

FILE: rtl/pairwise_euclidean_distance_core.sv
// Pairwise Euclidean distance engine. Write transactions (op = 0) store one
// Q7.8 coordinate of a point; query transactions (op = 1) return
// floor(sqrt(sum of squared coordinate differences)) of two points over the
// first dims_in_use dimensions (clamped to MAX_DIMS), with last_pair echoed
// on tlast. Coordinates live in a two-read, one-write memory with registered
// reads; reading a coordinate that was never written gives an arbitrary
// distance. A write does not hold the input side. A query holds the input
// side for one read pair per dimension, then read latency, squaring,
// accumulation and hand-off (only hand-off with no dimension in use). The
// square root runs behind the input side in a separate unit that resolves
// two root bits per cycle. It takes one query at a time and stays busy until
// its result moves to the output register; at the default sizes that unit
// sets the sustained query rate. Results wait in an output register; while
// tready is low, one more query can wait in the square root unit and another
// in the input side, and then the input side stalls.
`include "assert_macros.svh"

module pairwise_euclidean_distance_core
    import ped_pkg::*;
#(
    parameter int NUM_POINTS = 256,
    parameter int MAX_DIMS   = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // stream in
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // op[0], point_a[8:1], point_b[16:9], dim[18:17], coord[34:19], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tlast,
    // stream out
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // distance[16:0], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int PAW    = $clog2(NUM_POINTS);
    localparam int DAW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int ADDR_W = PAW + DAW;
    localparam int DEPTH  = NUM_POINTS * (2 ** DAW);
    localparam int USED_W = $clog2(MAX_DIMS + 1);
    localparam int SUM_W  = 36 + 4 * ($clog2(MAX_DIMS) / 4);
    localparam int ROOT_W = SUM_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int STEPS  = ROOT_W / 2;
    localparam int CNT_W  = $clog2(STEPS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_HAND = 2'd2;

    // configuration register
    logic             cfg_wr;
    logic [CFG_W-1:0] dims_in_use_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == ADDR_DIMS_IN_USE) ? APB_DATA_W'(dims_in_use_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_in_use_reg <= DIMS_RESET;
        end
        else if (cfg_wr && (paddr == ADDR_DIMS_IN_USE))
        begin
            dims_in_use_reg <= pwdata[CFG_W-1:0];
        end
    end

    // input fields
    logic               in_op;
    logic [POINT_W-1:0] in_point_a;
    logic [POINT_W-1:0] in_point_b;
    logic [DIM_W-1:0]   in_dim;
    logic [COORD_W-1:0] in_coord;
    logic               s_accept;
    logic [USED_W-1:0]  used_c;

    assign in_op      = s_tdata[0];
    assign in_point_a = s_tdata[8:1];
    assign in_point_b = s_tdata[16:9];
    assign in_dim     = s_tdata[18:17];
    assign in_coord   = s_tdata[34:19];
    assign s_accept   = s_tvalid && s_tready;
    assign used_c     = (32'(dims_in_use_reg) > MAX_DIMS) ? USED_W'(MAX_DIMS)
                                                          : USED_W'(dims_in_use_reg);

    // front end control
    logic [1:0]        state_reg, state_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic [USED_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic [USED_W-1:0] acc_cnt_reg, acc_cnt_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              sq_vld_reg, sq_vld_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              issuing;
    logic              sr_load;

    // front end payload
    logic [PAW-1:0]     pa_addr_reg;
    logic [PAW-1:0]     pb_addr_reg;
    logic               a_ok_reg;
    logic               b_ok_reg;
    logic               last_reg;
    logic [COORD_W-1:0] rd_a_reg;
    logic [COORD_W-1:0] rd_b_reg;
    logic [31:0]        sq_reg;

    // coordinate memory
    logic [COORD_W-1:0] coord_mem [DEPTH];
    logic               mem_we;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr_a;
    logic [ADDR_W-1:0]  rd_addr_b;

    assign mem_we    = s_accept && (in_op == OP_WRITE) && (32'(in_point_a) < NUM_POINTS)
                       && (32'(in_dim) < MAX_DIMS);
    assign wr_addr   = {PAW'(in_point_a), DAW'(in_dim)};
    assign rd_addr_a = {pa_addr_reg, issue_cnt_reg[DAW-1:0]};
    assign rd_addr_b = {pb_addr_reg, issue_cnt_reg[DAW-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            coord_mem[wr_addr] <= in_coord;
        end
        rd_a_reg <= coord_mem[rd_addr_a];
        rd_b_reg <= coord_mem[rd_addr_b];
    end

    // difference and square of one coordinate pair
    coord_t             a_val;
    coord_t             b_val;
    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]   diff_neg;
    logic [COORD_W-1:0] mag;

    assign a_val    = a_ok_reg ? coord_t'(rd_a_reg) : '0;
    assign b_val    = b_ok_reg ? coord_t'(rd_b_reg) : '0;
    assign diff     = (COORD_W+1)'(a_val) - (COORD_W+1)'(b_val);
    assign diff_neg = -diff;
    assign mag      = diff[COORD_W] ? diff_neg[COORD_W-1:0] : diff[COORD_W-1:0];

    always_ff @(posedge clk)
    begin
        sq_reg <= 32'(mag) * 32'(mag);
        if (s_accept && (in_op == OP_QUERY))
        begin
            pa_addr_reg <= PAW'(in_point_a);
            pb_addr_reg <= PAW'(in_point_b);
            a_ok_reg    <= 32'(in_point_a) < NUM_POINTS;
            b_ok_reg    <= 32'(in_point_b) < NUM_POINTS;
            last_reg    <= s_tlast;
        end
    end

    logic sr_busy_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign issuing  = (issue_cnt_reg < used_reg);
    assign sr_load  = (state_reg == S_HAND) && !sr_busy_reg;

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        issue_cnt_next = issue_cnt_reg;
        acc_cnt_next   = acc_cnt_reg;
        sum_next       = sum_reg;
        rd_vld_next    = 1'b0;
        sq_vld_next    = rd_vld_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_accept && (in_op == OP_QUERY))
                begin
                    used_next      = used_c;
                    issue_cnt_next = '0;
                    acc_cnt_next   = '0;
                    sum_next       = '0;
                    state_next     = (used_c == '0) ? S_HAND : S_RUN;
                end
            end
            S_RUN:
            begin
                if (issuing)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    rd_vld_next    = 1'b1;
                end
                if (sq_vld_reg)
                begin
                    sum_next     = sum_reg + SUM_W'(sq_reg);
                    acc_cnt_next = acc_cnt_reg + 1'b1;
                    if (acc_cnt_next == used_reg)
                    begin
                        state_next = S_HAND;
                    end
                end
            end
            S_HAND:
            begin
                if (!sr_busy_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            issue_cnt_reg <= '0;
            acc_cnt_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            sq_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            issue_cnt_reg <= issue_cnt_next;
            acc_cnt_reg   <= acc_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            sq_vld_reg    <= sq_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    // square root: two root bits per cycle
    logic [CNT_W-1:0]  sr_cnt_reg, sr_cnt_next;
    logic              sr_busy_next;
    logic [SUM_W-1:0]  sr_val_reg, sr_val_next;
    logic [REM_W-1:0]  sr_rem_reg, sr_rem_next;
    logic [ROOT_W-1:0] sr_root_reg, sr_root_next;
    logic              sr_last_reg;
    logic              sr_ready;
    logic              out_load;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [DIST_W-1:0] out_dist_reg;
    logic              out_last_reg;

    assign sr_ready = sr_busy_reg && (sr_cnt_reg == CNT_W'(STEPS));
    assign out_load = sr_ready && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        logic [REM_W:0]    rs;
        logic [REM_W:0]    trial;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [SUM_W-1:0]  val;
        rem  = sr_rem_reg;
        root = sr_root_reg;
        val  = sr_val_reg;
        for (int k = 0; k < 2; k++)
        begin
            rs    = {rem[REM_W-2:0], val[SUM_W-1 -: 2]};
            trial = {1'b0, root, 2'b01};
            if (rs >= trial)
            begin
                rs   = rs - trial;
                root = {root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                root = {root[ROOT_W-2:0], 1'b0};
            end
            rem = rs[REM_W-1:0];
            val = {val[SUM_W-3:0], 2'b00};
        end

        sr_busy_next = sr_busy_reg;
        sr_cnt_next  = sr_cnt_reg;
        sr_val_next  = sr_val_reg;
        sr_rem_next  = sr_rem_reg;
        sr_root_next = sr_root_reg;
        if (sr_load)
        begin
            sr_busy_next = 1'b1;
            sr_cnt_next  = '0;
            sr_val_next  = sum_reg;
            sr_rem_next  = '0;
            sr_root_next = '0;
        end
        else if (sr_busy_reg && !sr_ready)
        begin
            sr_cnt_next  = sr_cnt_reg + 1'b1;
            sr_val_next  = val;
            sr_rem_next  = rem;
            sr_root_next = root;
        end
        else if (out_load)
        begin
            sr_busy_next = 1'b0;
        end

        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_busy_reg  <= 1'b0;
            sr_cnt_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            sr_busy_reg  <= sr_busy_next;
            sr_cnt_reg   <= sr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_val_reg  <= sr_val_next;
        sr_rem_reg  <= sr_rem_next;
        sr_root_reg <= sr_root_next;
        if (sr_load)
        begin
            sr_last_reg <= last_reg;
        end
        if (out_load)
        begin
            // distance is the low bits of the root
            out_dist_reg <= sr_root_reg[DIST_W-1:0];
            out_last_reg <= sr_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_TDATA_W-DIST_W)'(0), out_dist_reg};
    assign m_tlast  = out_last_reg;

    `ASSERT_IMPLY(a_issue_bound, state_reg == S_RUN, issue_cnt_reg <= used_reg,
        "read issue count ran past the dimensions in use")
    `ASSERT_IMPLY(a_acc_behind_issue, state_reg == S_RUN, acc_cnt_reg <= issue_cnt_reg,
        "accumulated more squares than reads issued")
    `ASSERT_IMPLY(a_square_in_run, sq_vld_reg, state_reg == S_RUN,
        "square arrived outside the accumulation phase")
    `ASSERT_ALWAYS(a_sqrt_count, sr_cnt_reg <= CNT_W'(STEPS),
        "square root step count overran")

endmodule
